// ===== rtl/stick_smooth_and_calibrate_defines.svh =====
// Assertion macros shared by the stick smoothing and calibration RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef STICK_SMOOTH_AND_CALIBRATE_DEFINES_SVH
`define STICK_SMOOTH_AND_CALIBRATE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define SSC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define SSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ssc_pkg.sv =====
// Package for the stick smoothing and calibration block: constants, register
// indexes and the sequencer state type. No dependencies.
`timescale 1ns / 1ps

package ssc_pkg;

    // Defaults for the top-level parameters
    localparam int RAW_BITS_DEF     = 12;
    localparam int NUM_CHANNELS_DEF = 4;

    // Field widths
    localparam int CH_FIELD_W = 2;
    localparam int CMD_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int ALPHA_W    = 17;
    localparam int NUM_CAL    = 4;

    // Calibration word packing
    localparam int CAL_PT_W    = 12;
    localparam int CAL_SCALE_W = 20;
    localparam int CAL_MIN_LO  = 0;
    localparam int CAL_MID_LO  = 12;
    localparam int CAL_LS_LO   = 24;
    localparam int CAL_RS_LO   = 44;

    // Fixed-point constants
    localparam int ALPHA_ONE     = 65536;
    localparam int EMA_FRAC      = 16;
    localparam int SCALE_FRAC    = 13;
    localparam int HALF_SPAN_Q13 = 1044480;          // 127.5 in Q.13
    localparam int FULL_Q13      = 255 << SCALE_FRAC;
    localparam int EMA_SEED      = 1000;
    localparam int SEED_INT_W    = 10;               // bits to hold the seed

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_THROTTLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_YAW      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_PITCH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_ROLL     = 3'd4;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EMA,
        S_WB,
        S_CAL,
        S_OUT
    } ssc_state_t;

endpackage

// ===== rtl/ssc_if.sv =====
// Valid/ready channel interfaces for the stick smoothing and calibration block.
// Depends on ssc_pkg for field widths.
`timescale 1ns / 1ps

// Raw sample channel
interface ssc_in_if #(
    parameter int RAW_BITS = ssc_pkg::RAW_BITS_DEF
);
    logic                              valid;
    logic                              ready;
    logic [ssc_pkg::CH_FIELD_W-1:0]    stick_channel;
    logic [RAW_BITS-1:0]               raw_value;

    modport source (output valid, output stick_channel, output raw_value, input ready);
    modport sink   (input valid, input stick_channel, input raw_value, output ready);
endinterface

// Command result channel
interface ssc_out_if;
    logic                              valid;
    logic                              ready;
    logic [ssc_pkg::CH_FIELD_W-1:0]    out_channel;
    logic [ssc_pkg::CMD_W-1:0]         command;

    modport source (output valid, output out_channel, output command, input ready);
    modport sink   (input valid, input out_channel, input command, output ready);
endinterface

// Configuration write channel
interface ssc_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [ssc_pkg::CFG_IDX_W-1:0]     index;
    logic [ssc_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/ssc_calmap.sv =====
// Piecewise-linear calibration map: one registered multiply, then offset,
// saturation and truncation to an 8-bit command. Depends on ssc_pkg.
`timescale 1ns / 1ps

module ssc_calmap #(
    parameter int RAW_BITS = ssc_pkg::RAW_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 load,
    input  logic [((RAW_BITS > ssc_pkg::SEED_INT_W) ? RAW_BITS
                   : ssc_pkg::SEED_INT_W)-1:0]   v,
    input  logic [ssc_pkg::CFG_DATA_W-1:0]       cal,
    output logic [ssc_pkg::CMD_W-1:0]            cmd
);
    import ssc_pkg::*;

    localparam int INT_W  = (RAW_BITS > SEED_INT_W) ? RAW_BITS : SEED_INT_W;
    localparam int DIFF_W = ((INT_W > CAL_PT_W) ? INT_W : CAL_PT_W) + 1;
    localparam int PROD_W = DIFF_W + CAL_SCALE_W + 1;
    localparam int X_W    = PROD_W + 1;

    logic [CAL_PT_W-1:0]       mn;
    logic [CAL_PT_W-1:0]       md;
    logic [CAL_SCALE_W-1:0]    ls;
    logic [CAL_SCALE_W-1:0]    rs;
    logic                      lower;
    logic signed [DIFF_W-1:0]  v_s;
    logic signed [DIFF_W-1:0]  diff;
    logic [CAL_SCALE_W-1:0]    scl;
    logic signed [PROD_W-1:0]  prod;
    logic signed [PROD_W-1:0]  prod_reg;
    logic                      upper_reg;
    logic signed [X_W-1:0]     x;

    // Unpack the calibration word
    assign mn = cal[CAL_MIN_LO +: CAL_PT_W];
    assign md = cal[CAL_MID_LO +: CAL_PT_W];
    assign ls = cal[CAL_LS_LO  +: CAL_SCALE_W];
    assign rs = cal[CAL_RS_LO  +: CAL_SCALE_W];

    // Pick the segment and form the scaled offset
    always_comb
    begin
        v_s   = $signed({{(DIFF_W-INT_W){1'b0}}, v});
        lower = (v_s <= $signed({{(DIFF_W-CAL_PT_W){1'b0}}, md}));
        if (lower)
        begin
            diff = v_s - $signed({{(DIFF_W-CAL_PT_W){1'b0}}, mn});
            scl  = ls;
        end
        else
        begin
            diff = v_s - $signed({{(DIFF_W-CAL_PT_W){1'b0}}, md});
            scl  = rs;
        end
        prod = diff * $signed({1'b0, scl});
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg  <= prod;
            upper_reg <= !lower;
        end
    end

    // Offset the upper half, then saturate and truncate
    always_comb
    begin
        x = X_W'(prod_reg) + (upper_reg ? $signed(X_W'(HALF_SPAN_Q13)) : $signed(X_W'(0)));
        priority if (x < $signed(X_W'(0)))
            cmd = '0;
        else if (x >= $signed(X_W'(FULL_Q13)))
            cmd = '1;
        else
            cmd = x[SCALE_FRAC +: CMD_W];
    end

endmodule

// ===== rtl/stick_smooth_and_calibrate.sv =====
// Stick smoothing and calibration top level: per-channel moving average in a
// small synchronous memory, then the calibration map. Depends on ssc_pkg,
// ssc_if.sv, ssc_calmap and stick_smooth_and_calibrate_defines.svh.
//
// Usage:
//   sample  - raw stick items (stick_channel, raw_value), valid/ready.
//   result  - one item per sample (out_channel, command), valid/ready.
//   cfg     - register writes (index, data); always ready. Index 0 is the
//             smoothing weight, 1..4 the calibration words of channels 0..3,
//             higher indexes are ignored. Write only while the block is idle.
// Timing: a sample is accepted and its average is read from the state memory
// on that same edge, the two weight products are registered, the sum is written
// back, the calibration product is registered and the command is loaded into
// the output register, which drives result.valid. A new sample is
// taken in the cycle the previous result is loaded, so the block works on one
// item at a time, its pace set by the read / multiply / write-back sequence on
// the single-port state memory.
// Reset: every channel average reads as 1000.0 until first written (per-entry
// valid bits); weight is 0.5, calibration words are zero. No clearing pass.
// Stall: a held result keeps the item in its last step; sample.ready stays low
// until the output register frees up.
`timescale 1ns / 1ps
`include "stick_smooth_and_calibrate_defines.svh"

module stick_smooth_and_calibrate #(
    parameter int RAW_BITS     = ssc_pkg::RAW_BITS_DEF,
    parameter int NUM_CHANNELS = ssc_pkg::NUM_CHANNELS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    ssc_in_if.sink     sample,
    ssc_out_if.source  result,
    ssc_cfg_if.sink    cfg
);
    import ssc_pkg::*;

    localparam int INT_W = (RAW_BITS > SEED_INT_W) ? RAW_BITS : SEED_INT_W;
    localparam int EMA_W = INT_W + EMA_FRAC;
    localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int KP_W  = EMA_W + ALPHA_W;
    localparam int NP_W  = RAW_BITS + ALPHA_W;

    // Configuration registers
    logic [ALPHA_W-1:0]     alpha_reg;
    logic [CFG_DATA_W-1:0]  cal_reg [NUM_CAL];

    // Sequencer and item registers
    ssc_state_t             state_reg, state_next;
    logic [CH_FIELD_W-1:0]  ch_reg;
    logic [CH_W-1:0]        idx_reg;
    logic                   pres_reg;
    logic [RAW_BITS-1:0]    raw_reg;
    logic [ALPHA_W-1:0]     a_reg;
    logic                   seen_reg;
    logic [EMA_W-1:0]       rd_q_reg;
    logic [KP_W-1:0]        keep_prod_reg;
    logic [NP_W-1:0]        new_prod_reg;
    logic [INT_W-1:0]       v_reg;

    // State memory and its valid bits
    logic [EMA_W-1:0]        ema_mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] seen_vec_reg;

    // Output register
    logic                   out_valid_reg;
    logic [CH_FIELD_W-1:0]  out_ch_reg;
    logic [CMD_W-1:0]       out_cmd_reg;

    logic                   in_acc;
    logic                   out_free;
    logic                   out_load;
    logic                   mem_we;
    logic [3:0]             ch4;
    logic                   in_pres;
    logic [CH_W-1:0]        rd_idx;
    logic [ALPHA_W-1:0]     a_sat;
    logic [EMA_W-1:0]       ema_cur;
    logic [EMA_W:0]         ema_sum;
    logic [EMA_W-1:0]       ema_new;
    logic [CMD_W-1:0]       map_cmd;
    logic [CMD_W-1:0]       cmd_final;

    // Configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= ALPHA_W'(ALPHA_ONE / 2);
            for (int i = 0; i < NUM_CAL; i++)
                cal_reg[i] <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_ALPHA:        alpha_reg  <= cfg.data[ALPHA_W-1:0];
                REG_CAL_THROTTLE: cal_reg[0] <= cfg.data;
                REG_CAL_YAW:      cal_reg[1] <= cfg.data;
                REG_CAL_PITCH:    cal_reg[2] <= cfg.data;
                REG_CAL_ROLL:     cal_reg[3] <= cfg.data;
                default:          ;
            endcase
        end
    end

    // Handshakes
    assign out_free     = !out_valid_reg || result.ready;
    assign out_load     = (state_reg == S_OUT) && out_free;
    assign sample.ready = (state_reg == S_IDLE) || out_load;
    assign in_acc       = sample.valid && sample.ready;
    assign mem_we       = (state_reg == S_WB) && pres_reg;

    // Channel decode and weight clamp
    assign ch4     = {2'b00, sample.stick_channel};
    assign in_pres = (ch4 < 4'(NUM_CHANNELS));
    assign rd_idx  = in_pres ? ch4[CH_W-1:0] : '0;
    assign a_sat   = (alpha_reg > ALPHA_W'(ALPHA_ONE)) ? ALPHA_W'(ALPHA_ONE) : alpha_reg;

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_acc) state_next = S_EMA;
            S_EMA:   state_next = S_WB;
            S_WB:    state_next = S_CAL;
            S_CAL:   state_next = S_OUT;
            S_OUT:
            begin
                if (in_acc)
                    state_next = S_EMA;
                else if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Item capture and memory read
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            ch_reg   <= sample.stick_channel;
            idx_reg  <= rd_idx;
            pres_reg <= in_pres;
            raw_reg  <= sample.raw_value;
            a_reg    <= a_sat;
            seen_reg <= seen_vec_reg[rd_idx];
            rd_q_reg <= ema_mem[rd_idx];
        end
    end

    // Memory write-back
    always_ff @(posedge clk)
    begin
        if (mem_we)
            ema_mem[idx_reg] <= ema_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_vec_reg <= '0;
        else if (mem_we)
            seen_vec_reg[idx_reg] <= 1'b1;
    end

    // Weight products: keep part and new-sample part
    assign ema_cur = seen_reg ? rd_q_reg : EMA_W'(EMA_SEED << EMA_FRAC);

    always_ff @(posedge clk)
    begin
        if (state_reg == S_EMA)
        begin
            keep_prod_reg <= KP_W'(ema_cur) * KP_W'(ALPHA_W'(ALPHA_ONE) - a_reg);
            new_prod_reg  <= NP_W'(raw_reg) * NP_W'(a_reg);
        end
    end

    // New average: raw*a + floor(ema*(1-a))
    assign ema_sum = (EMA_W+1)'(new_prod_reg) + keep_prod_reg[KP_W-1:EMA_FRAC];
    assign ema_new = ema_sum[EMA_W-1:0];

    always_ff @(posedge clk)
    begin
        if (state_reg == S_WB)
            v_reg <= ema_new[EMA_W-1:EMA_FRAC];
    end

    // Calibration map
    ssc_calmap #(
        .RAW_BITS (RAW_BITS)
    ) u_calmap (
        .clk  (clk),
        .load (state_reg == S_CAL),
        .v    (v_reg),
        .cal  (cal_reg[ch_reg]),
        .cmd  (map_cmd)
    );

    // Pitch and roll are inverted; absent channels give zero
    assign cmd_final = !pres_reg ? '0 : (ch_reg[1] ? ~map_cmd : map_cmd);

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_load || (out_valid_reg && !result.ready);
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_ch_reg  <= ch_reg;
            out_cmd_reg <= cmd_final;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.out_channel = out_ch_reg;
    assign result.command     = out_cmd_reg;

    // Checks
    `SSC_ASSERT_NOW(a_we_only_wb, clk, rst_n, mem_we, (state_reg == S_WB) && pres_reg, "state write outside write-back")
    `SSC_ASSERT_NOW(a_no_overwrite, clk, rst_n, out_load, !out_valid_reg || result.ready, "held result overwritten")
    `SSC_ASSERT_NEXT(a_seen_set, clk, rst_n, mem_we, seen_vec_reg[idx_reg], "entry not marked valid after write")
    `SSC_ASSERT_NOW(a_ready_state, clk, rst_n, sample.ready, (state_reg == S_IDLE) || (state_reg == S_OUT), "sample taken mid-item")

endmodule

// ===== sim/tb_top.sv =====
// Self-checking bench for stick_smooth_and_calibrate: random and directed stick
// items against an in-bench fixed-point predictor, with random stalls on both sides.
// Depends on ssc_pkg, the channel interfaces in ssc_if.sv and the RTL top level.
`timescale 1ns / 1ps

module tb_top;
    import ssc_pkg::*;

    localparam int RAW_W           = RAW_BITS_DEF;
    localparam int NUM_CH          = NUM_CHANNELS_DEF;
    localparam int AVG_W           = RAW_W + EMA_FRAC;
    localparam int CLK_HALF        = 2;
    localparam int SETTLE_CYCLES   = 8;      // margin beyond the pipeline latency
    localparam int NUM_PHASES      = 10;
    localparam int ITEMS_PER_PHASE = 153;
    localparam int IDLE_PCT        = 20;
    localparam int HOLD_AT         = 400;    // results seen before the long hold-off
    localparam int HOLD_CYCLES     = 200;
    localparam int CALM_LO         = 700;    // window with no idling on either side
    localparam int CALM_HI         = 900;
    localparam int FIRST_INVERTED  = 2;      // pitch and roll are inverted

    localparam logic [CFG_IDX_W-1:0] REG_IDX_MAX = '1;

    typedef enum logic [1:0] {
        OP_SAMPLE,
        OP_WRITE,
        OP_DRAIN
    } op_kind_t;

    typedef struct {
        op_kind_t                kind;
        logic [CH_FIELD_W-1:0]   ch;
        logic [RAW_W-1:0]        raw;
        logic [CFG_IDX_W-1:0]    idx;
        logic [CFG_DATA_W-1:0]   data;
    } stim_op_t;

    typedef struct packed {
        logic [CH_FIELD_W-1:0] ch;
        logic [CMD_W-1:0]      command;
    } command_item_t;

    logic clk;
    logic rst_n;

    ssc_in_if #(.RAW_BITS(RAW_W)) sample_if();
    ssc_out_if                    result_if();
    ssc_cfg_if                    cfg_if();

    stick_smooth_and_calibrate #(
        .RAW_BITS     (RAW_W),
        .NUM_CHANNELS (NUM_CH)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    // Pending stimulus and expected commands
    stim_op_t      pending_ops[$];
    command_item_t expected_cmds[$];

    // Predictor copy of the registers and per-channel averages
    logic [ALPHA_W-1:0]    model_alpha;
    logic [CFG_DATA_W-1:0] model_cal [NUM_CAL];
    logic [AVG_W-1:0]      model_avg [NUM_CH];

    int errors;
    int n_samples;
    int n_writes;
    int n_results;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    // Run limit
    initial
    begin
        #2_000_000;
        $display("stick_smooth_and_calibrate regression: fail");
        $finish;
    end

    // Updates one channel's average and returns the command it maps to
    function automatic command_item_t predict_command(input logic [CH_FIELD_W-1:0] ch,
                                                      input logic [RAW_W-1:0] raw);
        logic [63:0]           weight;
        logic [63:0]           raw_q16;
        logic [63:0]           acc;
        logic [CFG_DATA_W-1:0] cal;
        longint                pos;
        longint                lo;
        longint                mid;
        longint                lsc;
        longint                rsc;
        longint                x;
        command_item_t         r;
        r.ch      = ch;
        r.command = '0;
        if (ch < NUM_CH)
        begin
            // weights above one saturate to one
            weight  = (model_alpha > ALPHA_ONE) ? 64'(ALPHA_ONE) : 64'(model_alpha);
            raw_q16 = 64'(raw) << EMA_FRAC;
            acc     = 64'(model_avg[ch]) * (64'(ALPHA_ONE) - weight) + raw_q16 * weight;
            model_avg[ch] = acc[EMA_FRAC +: AVG_W];

            // piecewise map around mid, all signed Q.13
            cal = model_cal[ch];
            pos = model_avg[ch][EMA_FRAC +: RAW_W];
            lo  = cal[CAL_MIN_LO +: CAL_PT_W];
            mid = cal[CAL_MID_LO +: CAL_PT_W];
            lsc = cal[CAL_LS_LO +: CAL_SCALE_W];
            rsc = cal[CAL_RS_LO +: CAL_SCALE_W];
            if (pos <= mid)
                x = (pos - lo) * lsc;
            else
                x = (pos - mid) * rsc + HALF_SPAN_Q13;

            if (x < 0)
                r.command = '0;
            else if (x >= FULL_Q13)
                r.command = '1;
            else
                r.command = CMD_W'(x >>> SCALE_FRAC);

            if (ch >= FIRST_INVERTED)
                r.command = ~r.command;   // 255 - command
        end
        return r;
    endfunction

    // Random calibration word: mostly sensible spans, plus noise and corner words
    function automatic logic [CFG_DATA_W-1:0] pick_cal_word();
        int unsigned mode;
        int unsigned lo;
        int unsigned mid;
        int unsigned hi;
        int unsigned lsc;
        int unsigned rsc;
        mode = $urandom_range(99);
        if (mode < 60)
        begin
            lo  = $urandom_range(1000);
            mid = $urandom_range(2600, 1500);
            hi  = $urandom_range(4095, 3000);
            lsc = HALF_SPAN_Q13 / (mid - lo);
            rsc = HALF_SPAN_Q13 / (hi - mid);
            lsc = lsc * 9 / 10 + $urandom_range(lsc / 5);
            rsc = rsc * 9 / 10 + $urandom_range(rsc / 5);
        end
        else if (mode < 75)
            return {$urandom, $urandom};
        else if (mode < 88)
        begin
            // min above mid, no swap in the block
            lo  = $urandom_range(4095, 2048);
            mid = $urandom_range(lo - 1);
            lsc = $urandom;
            rsc = $urandom;
        end
        else if (mode < 94)
            return '0;
        else
            return '1;
        return {CAL_SCALE_W'(rsc), CAL_SCALE_W'(lsc), CAL_PT_W'(mid), CAL_PT_W'(lo)};
    endfunction

    task automatic add_sample(input logic [CH_FIELD_W-1:0] ch, input logic [RAW_W-1:0] raw);
        stim_op_t op;
        op.kind = OP_SAMPLE;
        op.ch   = ch;
        op.raw  = raw;
        op.idx  = '0;
        op.data = '0;
        pending_ops.insert(pending_ops.size(), op);
    endtask

    task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        stim_op_t op;
        op.kind = OP_WRITE;
        op.ch   = '0;
        op.raw  = '0;
        op.idx  = idx;
        op.data = data;
        pending_ops.insert(pending_ops.size(), op);
    endtask

    task automatic add_drain();
        stim_op_t op;
        op.kind = OP_DRAIN;
        op.ch   = '0;
        op.raw  = '0;
        op.idx  = '0;
        op.data = '0;
        pending_ops.insert(pending_ops.size(), op);
    endtask

    // Driver: one item on the sample or config channel at a time
    logic     s_fire;
    logic     c_fire;
    logic     next_sv;
    logic     next_cv;
    stim_op_t cur_op;
    int       settle_cnt;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            sample_if.valid <= 1'b0;
            cfg_if.valid    <= 1'b0;
            settle_cnt      = 0;
        end
        else
        begin
            s_fire = sample_if.valid && sample_if.ready;
            c_fire = cfg_if.valid && cfg_if.ready;
            if (s_fire)
            begin
                expected_cmds.insert(expected_cmds.size(),
                                     predict_command(sample_if.stick_channel,
                                                     sample_if.raw_value));
                n_samples++;
            end
            if (c_fire)
            begin
                if (cfg_if.index == REG_ALPHA)
                    model_alpha = cfg_if.data[ALPHA_W-1:0];
                else if (cfg_if.index <= REG_CAL_ROLL)
                    model_cal[2'(cfg_if.index - REG_CAL_THROTTLE)] = cfg_if.data;
                n_writes++;
            end

            next_sv = sample_if.valid && !s_fire;
            next_cv = cfg_if.valid && !c_fire;
            if (!next_sv && !next_cv && pending_ops.size() > 0)
            begin
                cur_op = pending_ops[0];
                case (cur_op.kind)
                    OP_DRAIN:
                    begin
                        // wait for every command, then let the pipeline settle
                        if (expected_cmds.size() != 0)
                            settle_cnt = 0;
                        else if (settle_cnt < SETTLE_CYCLES)
                            settle_cnt++;
                        else
                        begin
                            settle_cnt = 0;
                            void'(pending_ops.pop_front());
                        end
                    end
                    OP_WRITE:
                    begin
                        void'(pending_ops.pop_front());
                        cfg_if.index <= cur_op.idx;
                        cfg_if.data  <= cur_op.data;
                        next_cv = 1'b1;
                    end
                    default:
                    begin
                        if ((n_samples >= CALM_LO && n_samples < CALM_HI) ||
                            $urandom_range(99) >= IDLE_PCT)
                        begin
                            void'(pending_ops.pop_front());
                            sample_if.stick_channel <= cur_op.ch;
                            sample_if.raw_value     <= cur_op.raw;
                            next_sv = 1'b1;
                        end
                    end
                endcase
            end
            sample_if.valid <= next_sv;
            cfg_if.valid    <= next_cv;
        end
    end

    // Monitor: check each command against the oldest prediction, drive ready
    logic          next_ready;
    logic          hold_done;
    int            hold_left;
    command_item_t want;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
            hold_done = 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (result_if.valid && result_if.ready)
            begin
                if (expected_cmds.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected command: channel %0d, command %0d",
                             $time, result_if.out_channel, result_if.command);
                end
                else
                begin
                    want = expected_cmds.pop_front();
                    if (result_if.out_channel !== want.ch)
                    begin
                        errors++;
                        $display("%0t: out_channel mismatch: expected %0d, actual %0d",
                                 $time, want.ch, result_if.out_channel);
                    end
                    if (result_if.command !== want.command)
                    begin
                        errors++;
                        $display("%0t: command mismatch on channel %0d: expected %0d, actual %0d",
                                 $time, want.ch, want.command, result_if.command);
                    end
                end
                n_results++;
            end

            // one long hold-off so the block backs up into its input
            if (hold_left > 0)
            begin
                hold_left--;
                next_ready = 1'b0;
            end
            else if (!hold_done && n_results >= HOLD_AT)
            begin
                hold_done  = 1'b1;
                hold_left  = HOLD_CYCLES;
                next_ready = 1'b0;
            end
            else if (n_results >= CALM_LO && n_results < CALM_HI)
                next_ready = 1'b1;
            else
                next_ready = ($urandom_range(99) >= IDLE_PCT);
            result_if.ready <= next_ready;
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        logic [ALPHA_W-1:0]    alpha;
        logic [CFG_DATA_W-1:0] phase_cal [NUM_CAL];
        logic [CH_FIELD_W-1:0] ch;
        logic [RAW_W-1:0]      raw;
        logic [RAW_W-1:0]      mid_pt;
        int                    step;
        int                    run;
        int                    left;
        int                    mode;

        rst_n                   = 1'b0;
        sample_if.valid         = 1'b0;
        sample_if.stick_channel = '0;
        sample_if.raw_value     = '0;
        cfg_if.valid            = 1'b0;
        cfg_if.index            = '0;
        cfg_if.data             = '0;
        result_if.ready         = 1'b0;
        errors                  = 0;
        n_samples               = 0;
        n_writes                = 0;
        n_results               = 0;

        // reset state of the block
        model_alpha = ALPHA_W'(ALPHA_ONE / 2);
        for (int k = 0; k < NUM_CAL; k++)
            model_cal[k] = '0;
        for (int k = 0; k < NUM_CH; k++)
            model_avg[k] = AVG_W'(EMA_SEED) << EMA_FRAC;

        // Zero calibration after reset: extremes on every channel
        for (int k = 0; k < NUM_CH; k++)
        begin
            add_sample(CH_FIELD_W'(k), '0);
            add_sample(CH_FIELD_W'(k), '1);
        end

        // Weight above one, a centered calibration, writes to unused indexes
        add_drain();
        add_write(REG_ALPHA, '1);
        for (int k = 0; k < NUM_CAL; k++)
            add_write(CFG_IDX_W'(REG_CAL_THROTTLE + k), {20'd510, 20'd510, 12'd2048, 12'd0});
        for (int i = REG_CAL_ROLL + 1; i <= REG_IDX_MAX; i++)
            add_write(CFG_IDX_W'(i), {$urandom, $urandom});
        add_sample(2'd0, '0);
        add_sample(2'd1, 12'd2048);
        add_sample(2'd2, 12'd2049);
        add_sample(2'd3, '1);
        add_sample(2'd0, '1);

        // Zero weight holds the averages; min above mid on throttle and yaw, full-scale slopes
        add_drain();
        add_write(REG_ALPHA, '0);
        add_write(REG_CAL_THROTTLE, {20'hFFFFF, 20'hFFFFF, 12'd1000, 12'd3000});
        add_write(REG_CAL_YAW, {20'hFFFFF, 20'hFFFFF, 12'd1000, 12'd3000});
        add_write(REG_CAL_PITCH, {20'hFFFFF, 20'hFFFFF, 12'd4095, 12'd4095});
        add_write(REG_CAL_ROLL, pick_cal_word());
        for (int k = 0; k < NUM_CH; k++)
            add_sample(CH_FIELD_W'(k), RAW_W'($urandom));

        // Random phases, each with fresh register settings
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:       alpha = ALPHA_W'(ALPHA_ONE);
                1:       alpha = ALPHA_W'(1);
                default:
                begin
                    case ($urandom_range(5))
                        0:       alpha = '0;
                        1:       alpha = ALPHA_W'(ALPHA_ONE);
                        2:       alpha = '1;
                        3:       alpha = ALPHA_W'($urandom);
                        4:       alpha = ALPHA_W'($urandom_range(2048, 1));
                        default: alpha = ALPHA_W'($urandom_range(65535, 1024));
                    endcase
                end
            endcase
            for (int k = 0; k < NUM_CAL; k++)
                phase_cal[k] = (p == 2) ? '1 : pick_cal_word();

            add_drain();
            add_write(REG_ALPHA, alpha);
            for (int k = 0; k < NUM_CAL; k++)
                add_write(CFG_IDX_W'(REG_CAL_THROTTLE + k), phase_cal[k]);
            add_write(CFG_IDX_W'(REG_CAL_ROLL + 1 +
                                 $urandom_range(REG_IDX_MAX - REG_CAL_ROLL - 1)),
                      {$urandom, $urandom});

            // runs of held sticks, sweeps, extremes and plain noise
            left = ITEMS_PER_PHASE;
            while (left > 0)
            begin
                run = $urandom_range(12, 1);
                if (run > left)
                    run = left;
                ch     = CH_FIELD_W'($urandom);
                raw    = RAW_W'($urandom);
                step   = $urandom_range(400, 1);
                mode   = $urandom_range(3);
                mid_pt = phase_cal[ch][CAL_MID_LO +: CAL_PT_W];
                for (int i = 0; i < run; i++)
                begin
                    case (mode)
                        0: add_sample(CH_FIELD_W'($urandom), RAW_W'($urandom));
                        1: add_sample(ch, raw);
                        2: add_sample(ch, RAW_W'(raw + i * step));
                        default:
                        begin
                            case ($urandom_range(2))
                                0:       add_sample(ch, '0);
                                1:       add_sample(ch, '1);
                                default: add_sample(ch, RAW_W'(mid_pt + $urandom_range(6) - 3));
                            endcase
                        end
                    endcase
                end
                left -= run;
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // drain everything, then allow for the pipeline latency
        while (pending_ops.size() != 0 || sample_if.valid || cfg_if.valid ||
               expected_cmds.size() != 0)
            @(posedge clk);
        repeat (4 * SETTLE_CYCLES) @(posedge clk);

        if (expected_cmds.size() != 0)
        begin
            errors++;
            $display("%0t: %0d commands never arrived", $time, expected_cmds.size());
        end

        $display("Checked %0d commands from %0d stick items over %0d register settings,",
                 n_results, n_samples, NUM_PHASES + 3);
        $display("with %0d register writes, random stalls and one long output hold-off.",
                 n_writes);
        if (errors == 0)
            $display("stick_smooth_and_calibrate regression: pass");
        else
            $display("stick_smooth_and_calibrate regression: fail");
        $finish;
    end

endmodule
